@@ hdl/send_on_delta_report_filter_defines.svh @@
// Assertion macros used by the report filter top level.
`ifndef SEND_ON_DELTA_REPORT_FILTER_DEFINES_SVH
`define SEND_ON_DELTA_REPORT_FILTER_DEFINES_SVH

// Clocked on clk_i, switched off while rst_ni is low
`define SOD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked on clk_i, checked during reset as well
`define SOD_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ hdl/sod_pkg.sv @@
// Types and constants of the send-on-delta report filter.
package sod_pkg;

  localparam int unsigned RD_W       = 16;  // sensor reading width
  localparam int unsigned TIME_W     = 32;  // millisecond time stamp width
  localparam int unsigned IVL_W      = 16;  // interval register width (seconds)
  localparam int unsigned MS_W       = 26;  // interval in milliseconds
  localparam int unsigned BD_W       = 8;   // band divisor register width
  localparam int unsigned DIV_W      = 15;  // band divisor times 100
  localparam int unsigned CNT_W      = 2;   // valid reading count width
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DIV_STEPS  = RD_W;  // one quotient bit per cycle
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  localparam logic [MS_W-1:0]  MS_PER_S   = MS_W'(1000);
  localparam logic [DIV_W-1:0] BAND_SCALE = DIV_W'(100);

  // Reset values of the configuration registers
  localparam logic [IVL_W-1:0] MIN_IVL_RST = IVL_W'(1);
  localparam logic [IVL_W-1:0] MAX_IVL_RST = IVL_W'(60);
  localparam logic [BD_W-1:0]  BAND_DIV_RST = BD_W'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_IVL  = 2'd0,
    CFG_MAX_IVL  = 2'd1,
    CFG_SMART    = 2'd2,
    CFG_BAND_DIV = 2'd3
  } sod_cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_DIV   = 4'b0100,
    ST_DONE  = 4'b1000
  } sod_state_e;

  // Decision for one poll, from the merge stage
  typedef struct packed {
    logic was_due;
    logic publish;
    logic forced;
    logic upd_ref;
  } sod_res_t;

endpackage

@@ hdl/sod_lane.sv @@
// One deadband lane: serial |ref|/divisor and the band test of one reading.
module sod_lane import sod_pkg::*; (
  input  logic                    clk_i,
  input  logic                    start_i,
  input  logic                    step_i,
  input  logic signed [RD_W-1:0]  ref_i,
  input  logic signed [RD_W-1:0]  val_i,
  input  logic        [DIV_W-1:0] divisor_i,
  output logic                    oob_o
);

  logic        [RD_W-1:0]  quo_q, quo_d;
  logic        [DIV_W-1:0] rem_q, rem_d;
  logic signed [RD_W-1:0]  ref_q, val_q;
  logic        [RD_W-1:0]  mag;
  logic        [DIV_W:0]   trial;
  logic signed [RD_W+1:0]  ref_x, val_x, quo_x, lo, hi;

  // Magnitude of the reference; -32768 maps to 32768 as unsigned
  assign mag   = ref_i[RD_W-1] ? (~ref_i + RD_W'(1)) : ref_i;
  assign trial = {rem_q, quo_q[RD_W-1]};

  // Restoring division, dividend shifts out of the quotient register
  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    if (start_i) begin
      quo_d = mag;
      rem_d = '0;
    end else if (step_i) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = DIV_W'(trial - {1'b0, divisor_i});
        quo_d = {quo_q[RD_W-2:0], 1'b1};
      end else begin
        rem_d = trial[DIV_W-1:0];
        quo_d = {quo_q[RD_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      ref_q <= ref_i;
      val_q <= val_i;
    end
  end

  // Band test once the quotient is complete
  assign ref_x = (RD_W+2)'(ref_q);
  assign val_x = (RD_W+2)'(val_q);
  assign quo_x = $signed({2'b00, quo_q});
  assign lo    = ref_x - quo_x;
  assign hi    = ref_x + quo_x;
  assign oob_o = (val_x < lo) || (val_x > hi);

endmodule

@@ hdl/sod_merge.sv @@
// Merge stage: combines lane band results with the interval checks.
module sod_merge import sod_pkg::*; #(
  parameter int unsigned NUM_DIMS = 3
) (
  input  logic                 due_i,
  input  logic                 force_i,
  input  logic                 smart_i,
  input  logic [CNT_W-1:0]     count_i,
  input  logic [NUM_DIMS-1:0]  oob_i,
  output sod_res_t             res_o
);

  logic trig;
  logic taken;

  // Only the first valid_count lanes take part in the trigger
  always_comb begin
    trig = 1'b0;
    for (int i = 0; i < NUM_DIMS; i++) begin
      if (oob_i[i] && (i < int'(count_i))) trig = 1'b1;
    end
  end

  assign taken         = due_i && (count_i != '0);
  assign res_o.was_due = due_i;
  assign res_o.forced  = due_i && force_i;
  assign res_o.publish = taken && (force_i || !smart_i || trig);
  assign res_o.upd_ref = taken && !force_i && smart_i && trig;

endmodule

@@ hdl/send_on_delta_report_filter.sv @@
// Top level of the send-on-delta report filter with deadband.
//
// Channel  Dir  Handshake                  Beat
// in       in   in_valid_i / in_ready_o    now_ms, valid_count, reading_a..c
// out      out  out_valid_o / out_ready_i  was_due, publish, forced, out_a..c
// cfg      in   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// An item is captured and checked against the intervals; if the poll is due,
// the lanes then run a 16-step serial division, one quotient bit per cycle,
// else the division is skipped. A new beat is taken only once the last is done.
// The output register holds a finished beat while the next item is taken;
// the block waits in its last state only if that register is still full.
// Reset clears configuration to its defaults, both time stamps and references.
// Configuration writes are always taken.
`include "send_on_delta_report_filter_defines.svh"

module send_on_delta_report_filter import sod_pkg::*; #(
  parameter int unsigned NUM_DIMS = 3
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input beats
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic        [TIME_W-1:0]     now_ms_i,
  input  logic        [CNT_W-1:0]      valid_count_i,
  input  logic signed [RD_W-1:0]       reading_a_i,
  input  logic signed [RD_W-1:0]       reading_b_i,
  input  logic signed [RD_W-1:0]       reading_c_i,
  // result beats
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         was_due_o,
  output logic                         publish_o,
  output logic                         forced_o,
  output logic signed [RD_W-1:0]       out_a_o,
  output logic signed [RD_W-1:0]       out_b_o,
  output logic signed [RD_W-1:0]       out_c_o,
  // configuration writes
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic        [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic        [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned NUM_IN = 3;

  sod_state_e state_q, state_d;

  // configuration
  logic [IVL_W-1:0] min_ivl_q, max_ivl_q;
  logic             smart_q;
  logic [BD_W-1:0]  band_div_q;

  // state of the filter
  logic [TIME_W-1:0]                last_poll_q, last_pub_q;
  logic [NUM_DIMS-1:0][RD_W-1:0]    ref_q;

  // captured item
  logic [TIME_W-1:0]                now_q;
  logic [CNT_W-1:0]                 count_q;
  logic [NUM_IN-1:0][RD_W-1:0]      rd_q;

  // check stage
  logic [MS_W-1:0]   min_ms, max_ms;
  logic [TIME_W-1:0] poll_gap, pub_gap;
  logic [BD_W-1:0]   bd_eff;
  logic              due_q, force_q;
  logic [DIV_W-1:0]  divisor_q;
  logic [STEP_W-1:0] step_q;

  // lanes and merge
  logic [NUM_DIMS-1:0][RD_W-1:0] lane_val;
  logic [NUM_DIMS-1:0]           oob;
  logic                          lane_start, lane_step;
  sod_res_t                      res, res_q;

  // output register
  logic                          out_valid_q;
  logic [NUM_IN-1:0][RD_W-1:0]   out_rd_q;
  logic                          load;
  logic                          in_acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_ivl_q  <= MIN_IVL_RST;
      max_ivl_q  <= MAX_IVL_RST;
      smart_q    <= 1'b0;
      band_div_q <= BAND_DIV_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (sod_cfg_idx_e'(cfg_index_i))
        CFG_MIN_IVL:  min_ivl_q  <= cfg_data_i[IVL_W-1:0];
        CFG_MAX_IVL:  max_ivl_q  <= cfg_data_i[IVL_W-1:0];
        CFG_SMART:    smart_q    <= cfg_data_i[0];
        CFG_BAND_DIV: band_div_q <= cfg_data_i[BD_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture of an accepted beat
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q   <= now_ms_i;
      count_q <= valid_count_i;
      rd_q    <= {reading_c_i, reading_b_i, reading_a_i};
    end
  end

  // Interval checks, wrapping time differences
  assign min_ms   = MS_W'(min_ivl_q) * MS_PER_S;
  assign max_ms   = MS_W'(max_ivl_q) * MS_PER_S;
  assign poll_gap = now_q - last_poll_q;
  assign pub_gap  = now_q - last_pub_q;
  assign bd_eff   = (band_div_q == '0) ? BD_W'(1) : band_div_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CHECK) begin
      due_q     <= poll_gap >= TIME_W'(min_ms);
      force_q   <= pub_gap > TIME_W'(max_ms);
      divisor_q <= DIV_W'(bd_eff) * BAND_SCALE;
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_acc) state_d = ST_CHECK;
      ST_CHECK: state_d = (poll_gap >= TIME_W'(min_ms)) ? ST_DIV : ST_DONE;
      ST_DIV:   if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = ST_DONE;
      ST_DONE:  if (load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_DIV) step_q <= step_q + STEP_W'(1);
      else                   step_q <= '0;
    end
  end

  assign lane_start = (state_q == ST_CHECK);
  assign lane_step  = (state_q == ST_DIV);

  // One lane per dimension; dimensions past the input fields read as zero
  for (genvar i = 0; i < NUM_DIMS; i++) begin : g_lane
    if (i < NUM_IN) begin : g_in
      assign lane_val[i] = rd_q[i];
    end else begin : g_zero
      assign lane_val[i] = '0;
    end

    sod_lane u_lane (
      .clk_i     (clk_i),
      .start_i   (lane_start),
      .step_i    (lane_step),
      .ref_i     (ref_q[i]),
      .val_i     (lane_val[i]),
      .divisor_i (divisor_q),
      .oob_o     (oob[i])
    );
  end

  sod_merge #(
    .NUM_DIMS (NUM_DIMS)
  ) u_merge (
    .due_i   (due_q),
    .force_i (force_q),
    .smart_i (smart_q),
    .count_i (count_q),
    .oob_i   (oob),
    .res_o   (res)
  );

  assign load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  // State update at the end of a poll
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_poll_q <= '0;
      last_pub_q  <= '0;
      ref_q       <= '0;
    end else if (load) begin
      if (res.was_due) last_poll_q <= now_q;
      if (res.publish) last_pub_q  <= now_q;
      if (res.upd_ref) ref_q       <= lane_val;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q    <= res;
      out_rd_q <= res.publish ? rd_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign was_due_o   = res_q.was_due;
  assign publish_o   = res_q.publish;
  assign forced_o    = res_q.forced;
  assign out_a_o     = out_rd_q[0];
  assign out_b_o     = out_rd_q[1];
  assign out_c_o     = out_rd_q[2];

  // A publish or a force always comes from a due poll
  `SOD_ASSERT_ALWAYS(a_pub_needs_due, out_valid_o && !was_due_o |-> !publish_o && !forced_o, "publish or forced without due poll")
  // Readings leave only with a publish
  `SOD_ASSERT(a_zero_readings, out_valid_o && !publish_o |-> out_a_o == '0 && out_b_o == '0 && out_c_o == '0, "readings shown without publish")
  // References move only on a smart trigger at the end of a poll
  `SOD_ASSERT(a_ref_update, !$stable(ref_q) |-> $past(load) && $past(res.upd_ref), "reference changed outside a smart trigger")
  // After an accepted beat the block is busy with it
  `SOD_ASSERT(a_busy_after_accept, in_acc |=> !in_ready_o && !load, "input taken while an item is in progress")

endmodule
